>>> rtl/kvsm_pkg.sv
// ----------------------------------------------------------------------------
// kvsm_pkg
// Shared widths, codes and structures of the paged key/value slot mapper.
// ----------------------------------------------------------------------------
package kvsm_pkg;

	localparam int TABLE_DEPTH_DEF = 4096;
	localparam int MAX_RUN_DEF     = 64;

	localparam int KIND_W     = 2;
	localparam int SEQ_W      = 8;
	localparam int POS_W      = 16;
	localparam int CNT_W      = 7;
	localparam int LEN_W      = 17;
	localparam int ADDR_W     = 12;
	localparam int BID_W      = 16;
	localparam int SLOT_W     = 26;
	localparam int CFG_W      = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int QPOS_W     = 17;
	localparam int BASE_W     = SEQ_W + CFG_W;
	localparam int IDX_W      = BASE_W + 1;
	localparam int PROD_W     = BID_W + CFG_W;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 32;

	localparam logic [CFG_W-1:0] BLK_TOKENS_RST     = 11'd64;
	localparam logic [CFG_W-1:0] BLOCKS_PER_SEQ_RST = 11'd16;

	typedef enum logic [KIND_W-1:0] {
		KIND_WRITE   = 2'd0,
		KIND_PREFILL = 2'd1,
		KIND_DECODE  = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLK_TOKENS     = 2'd0,
		REG_BLOCKS_PER_SEQ = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              valid;
		logic              last;
		logic              fault_cfg;
		logic [QPOS_W-1:0] blk;
		logic [CFG_W-1:0]  off;
		logic [BASE_W-1:0] base;
	} pos_req_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [BID_W-1:0]  data;
	} tbl_wr_t;

endpackage

>>> rtl/kvsm_ram.sv
// ----------------------------------------------------------------------------
// kvsm_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module kvsm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/kvsm_div.sv
// ----------------------------------------------------------------------------
// kvsm_div
// Restoring divider that splits a token position into block number and
// offset, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kvsm_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [kvsm_pkg::QPOS_W-1:0] dividend,
	input  logic [kvsm_pkg::CFG_W-1:0]  divisor,
	output logic                       done,
	output logic [kvsm_pkg::QPOS_W-1:0] quot,
	output logic [kvsm_pkg::CFG_W-1:0]  rem
);
	import kvsm_pkg::*;

	localparam int CNT_BITS = $clog2(QPOS_W + 1);

	logic [QPOS_W-1:0]   q_q;
	logic [CFG_W:0]      r_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [CFG_W:0]      trial;
	logic                ge;

	assign trial = {r_q[CFG_W-1:0], q_q[QPOS_W-1]};
	assign ge    = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(QPOS_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
		end else if (busy_q) begin
			q_q <= {q_q[QPOS_W-2:0], ge};
			r_q <= ge ? (trial - {1'b0, divisor}) : trial;
		end
	end

	assign done = done_q;
	assign quot = q_q;
	assign rem  = r_q[CFG_W-1:0];

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start)
		else $error("divider restarted while busy");

endmodule

>>> rtl/kvsm_seq.sv
// ----------------------------------------------------------------------------
// kvsm_seq
// Item sequencer: takes input transactions, issues table writes, divides the
// first position of a run and steps block and offset once per position.
// ----------------------------------------------------------------------------
module kvsm_seq #(
	parameter int TABLE_DEPTH = kvsm_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_RUN     = kvsm_pkg::MAX_RUN_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [kvsm_pkg::KIND_W-1:0]  kind,
	input  logic [kvsm_pkg::SEQ_W-1:0]   seq_index,
	input  logic [kvsm_pkg::POS_W-1:0]   start_pos,
	input  logic [kvsm_pkg::CNT_W-1:0]   run_count,
	input  logic [kvsm_pkg::LEN_W-1:0]   cur_length,
	input  logic [kvsm_pkg::ADDR_W-1:0]  table_addr,
	input  logic [kvsm_pkg::BID_W-1:0]   block_id,
	input  logic [kvsm_pkg::CFG_W-1:0]   blk_tokens,
	input  logic [kvsm_pkg::CFG_W-1:0]   blocks_per_seq,
	output kvsm_pkg::pos_req_t           req,
	input  logic                         req_ready,
	output kvsm_pkg::tbl_wr_t            tbl_wr
);
	import kvsm_pkg::*;

	localparam int RUN_W = $clog2(MAX_RUN + 1);
	localparam logic [IDX_W-1:0] DEPTH_LIM = IDX_W'(TABLE_DEPTH);

	state_t             state_q;
	state_t             state_d;
	kind_t              kind_in;
	logic [RUN_W-1:0]   rem_cnt_q;
	logic [RUN_W-1:0]   sat_cnt;
	logic [SEQ_W-1:0]   seq_q;
	logic [BASE_W-1:0]  base_q;
	logic [QPOS_W-1:0]  blk_q;
	logic [CFG_W-1:0]   off_q;
	logic               zero_q;
	logic               accept;
	logic               has_work;
	logic               div_start;
	logic               div_done;
	logic [QPOS_W-1:0]  dividend;
	logic [QPOS_W-1:0]  div_quot;
	logic [CFG_W-1:0]   div_rem;
	logic [CFG_W:0]     off_inc;
	logic               step;

	assign kind_in = kind_t'(kind);
	assign accept  = in_valid && in_ready;
	assign step    = (state_q == ST_EMIT) && req_ready;
	assign off_inc = {1'b0, off_q} + (CFG_W + 1)'(1);

	always_comb begin
		if (run_count > CNT_W'(MAX_RUN)) begin
			sat_cnt = RUN_W'(MAX_RUN);
		end else begin
			sat_cnt = run_count[RUN_W-1:0];
		end
	end

	always_comb begin
		case (kind_in)
			KIND_PREFILL: begin
				has_work = run_count != '0;
				dividend = {1'b0, start_pos};
			end
			KIND_DECODE: begin
				has_work = cur_length != '0;
				dividend = cur_length - LEN_W'(1);
			end
			default: begin
				has_work = 1'b0;
				dividend = '0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && has_work) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (req_ready && rem_cnt_q == RUN_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready      = (state_q == ST_IDLE) && req_ready;
		div_start     = accept && has_work;
		req.valid     = state_q == ST_EMIT;
		req.last      = rem_cnt_q == RUN_W'(1);
		req.fault_cfg = zero_q;
		req.blk       = blk_q;
		req.off       = off_q;
		req.base      = base_q;
		tbl_wr.en     = accept && (kind_in == KIND_WRITE)
			&& (IDX_W'(table_addr) < DEPTH_LIM);
		tbl_wr.addr   = table_addr;
		tbl_wr.data   = block_id;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rem_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				rem_cnt_q <= (kind_in == KIND_DECODE) ? RUN_W'(1) : sat_cnt;
			end else if (step) begin
				rem_cnt_q <= rem_cnt_q - RUN_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			seq_q  <= seq_index;
			zero_q <= (blk_tokens == '0) || (blocks_per_seq == '0);
		end
		if (state_q == ST_DIV) begin
			base_q <= seq_q * blocks_per_seq;
			if (div_done) begin
				blk_q <= div_quot;
				off_q <= div_rem;
			end
		end else if (step) begin
			if (off_inc == {1'b0, blk_tokens}) begin
				off_q <= '0;
				blk_q <= blk_q + QPOS_W'(1);
			end else begin
				off_q <= off_inc[CFG_W-1:0];
			end
		end
	end

	kvsm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (blk_tokens),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req_ready && req.last |=> !req.valid)
		else $error("position issued after the last one of an item");

	a_emit_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (rem_cnt_q != '0))
		else $error("emitting with no positions left");

endmodule

>>> rtl/kvsm_lookup.sv
// ----------------------------------------------------------------------------
// kvsm_lookup
// Lookup pipeline: forms the table index, reads the block table, scales the
// block number and adds the offset into the output register.
// ----------------------------------------------------------------------------
module kvsm_lookup #(
	parameter int TABLE_DEPTH = kvsm_pkg::TABLE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  kvsm_pkg::pos_req_t          req,
	output logic                        req_ready,
	input  kvsm_pkg::tbl_wr_t           tbl_wr,
	input  logic [kvsm_pkg::CFG_W-1:0]  blk_tokens,
	input  logic [kvsm_pkg::CFG_W-1:0]  blocks_per_seq,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [kvsm_pkg::SLOT_W-1:0] out_slot,
	output logic                        out_last,
	output logic                        out_fault
);
	import kvsm_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam logic [IDX_W-1:0] DEPTH_LIM = IDX_W'(TABLE_DEPTH);

	logic              advance;
	logic [IDX_W-1:0]  idx;
	logic              fault_in;
	logic [IDX_W-1:0]  wr_addr_ext;
	logic [BID_W-1:0]  rdata;

	logic              valid_s1;
	logic              last_s1;
	logic              fault_s1;
	logic [CFG_W-1:0]  off_s1;
	logic [IDX_W-1:0]  idx_s1;

	logic              valid_s2;
	logic              last_s2;
	logic              fault_s2;
	logic [CFG_W-1:0]  off_s2;

	logic              valid_s3;
	logic              last_s3;
	logic              fault_s3;
	logic [CFG_W-1:0]  off_s3;
	logic [PROD_W-1:0] prod_s3;
	logic [PROD_W:0]   sum;

	logic              out_valid_q;
	logic              out_last_q;
	logic              out_fault_q;
	logic [SLOT_W-1:0] out_slot_q;

	assign advance     = !out_valid_q || out_ready;
	assign req_ready   = advance;
	assign idx         = IDX_W'(req.base) + IDX_W'(req.blk);
	assign fault_in    = req.fault_cfg || (req.blk >= QPOS_W'(blocks_per_seq))
		|| (idx >= DEPTH_LIM);
	assign wr_addr_ext = IDX_W'(tbl_wr.addr);
	assign sum         = {1'b0, prod_s3} + (PROD_W + 1)'(off_s3);

	// A table write is taken only between items and only while the pipeline
	// advances; a read issued in the same cycle belongs to an earlier item
	// and wants the old contents.
	kvsm_ram #(
		.WIDTH (BID_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (tbl_wr.en),
		.waddr (wr_addr_ext[AW-1:0]),
		.wdata (tbl_wr.data),
		.re    (advance),
		.raddr (idx_s1[AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= req.valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			last_s1     <= req.last;
			fault_s1    <= fault_in;
			off_s1      <= req.off;
			idx_s1      <= idx;
			last_s2     <= last_s1;
			fault_s2    <= fault_s1;
			off_s2      <= off_s1;
			last_s3     <= last_s2;
			fault_s3    <= fault_s2;
			off_s3      <= off_s2;
			prod_s3     <= rdata * blk_tokens;
			out_last_q  <= last_s3;
			out_fault_q <= fault_s3;
			out_slot_q  <= fault_s3 ? '0 : sum[SLOT_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_slot  = out_slot_q;
	assign out_last  = out_last_q;
	assign out_fault = out_fault_q;

endmodule

>>> rtl/paged_kv_slot_mapper.sv
// ----------------------------------------------------------------------------
// paged_kv_slot_mapper
// Maps token positions of sequences to physical slots of a paged KV cache.
//
// The slave stream takes one item per transaction: tuser holds the kind, tdata
// the remaining fields. A write item loads one block table word. A prefill
// item yields one slot per position of its run, capped at MAX_RUN; a decode
// item yields the slot of its last token. tlast marks the final slot of an
// item; tuser flags a zero setting, a block past blocks per sequence or an
// index outside the table. Block size and blocks per sequence are set on the
// configuration channel, which is always ready; it must be written only while
// the block is idle, which the block does not enforce. A prefill or decode
// item first passes through a restoring divider that splits its first position
// into block and offset; positions then leave the sequencer at one per cycle
// unless the receiver stalls, into a four-stage lookup pipeline (index, table
// read, scaling, output register). The next item is taken once the last
// position has left the sequencer, while the pipeline drains. When the receiver
// stalls, the whole pipeline holds, the sequencer waits and no new transaction
// is taken. Reset restores the register defaults; the block table is not
// cleared and holds no valid data until written.
// ----------------------------------------------------------------------------
module paged_kv_slot_mapper #(
	parameter int TABLE_DEPTH = kvsm_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_RUN     = kvsm_pkg::MAX_RUN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// tdata: seq_index, start_pos, run_count, cur_length, table_addr, block_id
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [kvsm_pkg::IN_DATA_W-1:0]  s_tdata,
	// tuser: kind
	input  logic [kvsm_pkg::KIND_W-1:0]     s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// tdata: slot
	output logic [kvsm_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                            m_tlast,
	// tuser: fault
	output logic                            m_tuser,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [kvsm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [kvsm_pkg::CFG_W-1:0]      cfg_data
);
	import kvsm_pkg::*;

	logic [CFG_W-1:0]  blk_tokens_q;
	logic [CFG_W-1:0]  blocks_per_seq_q;
	pos_req_t          req;
	logic              req_ready;
	tbl_wr_t           tbl_wr;
	logic [SLOT_W-1:0] slot;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_tokens_q     <= BLK_TOKENS_RST;
			blocks_per_seq_q <= BLOCKS_PER_SEQ_RST;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_BLK_TOKENS: begin
					blk_tokens_q <= cfg_data;
				end
				REG_BLOCKS_PER_SEQ: begin
					blocks_per_seq_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	kvsm_seq #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.MAX_RUN     (MAX_RUN)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.kind           (s_tuser),
		.seq_index      (s_tdata[7:0]),
		.start_pos      (s_tdata[23:8]),
		.run_count      (s_tdata[30:24]),
		.cur_length     (s_tdata[47:31]),
		.table_addr     (s_tdata[59:48]),
		.block_id       (s_tdata[75:60]),
		.blk_tokens     (blk_tokens_q),
		.blocks_per_seq (blocks_per_seq_q),
		.req            (req),
		.req_ready      (req_ready),
		.tbl_wr         (tbl_wr)
	);

	kvsm_lookup #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_lookup (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req),
		.req_ready      (req_ready),
		.tbl_wr         (tbl_wr),
		.blk_tokens     (blk_tokens_q),
		.blocks_per_seq (blocks_per_seq_q),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_slot       (slot),
		.out_last       (m_tlast),
		.out_fault      (m_tuser)
	);

	assign m_tdata = OUT_DATA_W'(slot);

endmodule
